### rtl/blearp_pkg.sv
package blearp_pkg;

	localparam int ADDR_W  = 48;
	localparam int POS_W   = 5;
	localparam int TDATA_W = 72;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DONE  = 2'd1,
		ST_WRONG = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	// subevent codes
	localparam logic [7:0] SUBEV_CONN_DONE  = 8'h01;
	localparam logic [7:0] SUBEV_ADV_REPORT = 8'h02;

	// AD record types that carry a local name
	localparam logic [7:0] AD_SHORT_NAME    = 8'h08;
	localparam logic [7:0] AD_COMPLETE_NAME = 8'h09;

	// header byte positions
	localparam logic [3:0] HDR_FIRST      = 4'd0;
	localparam logic [3:0] HDR_SUBEVENT   = 4'd3;
	localparam logic [3:0] HDR_ADDR_FIRST = 4'd7;
	localparam logic [3:0] HDR_DATA_LEN   = 4'd13;

	localparam int ADDR_BYTES = 6;

	// summary request from the parser to the output stage
	typedef struct packed {
		logic               valid;
		status_t            status;
		logic [ADDR_W-1:0]  addr;
		logic signed [7:0]  rssi;
		logic               burst;
		logic               last;
	} summary_t;

endpackage

### rtl/blearp_name_mem.sv
module blearp_name_mem #(
	parameter int NAME_BYTES = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          wr_en,
	input  logic [$clog2(NAME_BYTES)-1:0] wr_idx,
	input  logic [7:0]                    wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(NAME_BYTES)-1:0] rd_idx,
	output logic [7:0]                    rd_data
);

	logic [7:0]            mem [NAME_BYTES];
	logic [NAME_BYTES-1:0] vld_q;
	logic [7:0]            rd_s1;
	logic                  rd_vld_s1;

	// entry valid bits; an entry never written since the last clear reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1     <= mem[rd_idx];
			rd_vld_s1 <= vld_q[rd_idx];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_s1 : 8'h00;

endmodule

### rtl/blearp_parse.sv
module blearp_parse #(
	parameter int NAME_BYTES = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_packet,
	output logic                          mem_clear,
	output logic                          mem_wr_en,
	output logic [$clog2(NAME_BYTES)-1:0] mem_wr_idx,
	output logic [7:0]                    mem_wr_data,
	output blearp_pkg::summary_t          sum
);

	localparam int IW  = $clog2(NAME_BYTES);
	localparam int IW1 = $clog2(NAME_BYTES + 1);
	localparam logic [7:0]     NB8  = 8'(NAME_BYTES);
	localparam logic [IW1-1:0] NBW  = IW1'(NAME_BYTES);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_REC_LEN,
		PH_REC_TYPE,
		PH_REC_VALUE,
		PH_RSSI,
		PH_DRAIN
	} phase_t;

	phase_t                        phase_q, phase_n;
	logic [3:0]                    hdr_cnt_q, hdr_cnt_n;
	logic [7:0]                    data_rem_q, data_rem_n;
	logic [7:0]                    rec_rem_q, rec_rem_n;
	logic                          is_name_q, is_name_n;
	logic                          stop_q, stop_n;
	logic [IW1-1:0]                wr_idx_q, wr_idx_n;
	logic [blearp_pkg::ADDR_W-1:0] addr_q, addr_n;
	logic                          emitted_q, emitted_n;
	logic [7:0]                    rr;

	always_comb begin
		phase_n    = phase_q;
		hdr_cnt_n  = hdr_cnt_q;
		data_rem_n = data_rem_q;
		rec_rem_n  = rec_rem_q;
		is_name_n  = is_name_q;
		stop_n     = stop_q;
		wr_idx_n   = wr_idx_q;
		addr_n     = addr_q;
		emitted_n  = emitted_q;
		rr         = rec_rem_q - 8'd1;
		mem_clear  = 1'b0;
		mem_wr_en  = 1'b0;
		mem_wr_idx = wr_idx_q[IW-1:0];
		mem_wr_data = data_byte;
		sum        = '0;
		if (in_fire) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q == blearp_pkg::HDR_FIRST) begin
						mem_clear = 1'b1;
					end
					if (hdr_cnt_q == blearp_pkg::HDR_SUBEVENT &&
					    data_byte != blearp_pkg::SUBEV_ADV_REPORT) begin
						sum.valid  = 1'b1;
						sum.status = (data_byte == blearp_pkg::SUBEV_CONN_DONE) ?
						             blearp_pkg::ST_DONE : blearp_pkg::ST_WRONG;
						sum.addr   = addr_q;
						sum.last   = 1'b1;
						emitted_n  = 1'b1;
						phase_n    = PH_DRAIN;
					end else if (hdr_cnt_q == blearp_pkg::HDR_DATA_LEN) begin
						data_rem_n = data_byte;
						phase_n    = (data_byte != 8'd0) ? PH_REC_LEN : PH_RSSI;
					end else begin
						for (int k = 0; k < blearp_pkg::ADDR_BYTES; k++) begin
							if (hdr_cnt_q == blearp_pkg::HDR_ADDR_FIRST + 4'(k)) begin
								addr_n[8*k +: 8] = addr_q[8*k +: 8] | data_byte;
							end
						end
						hdr_cnt_n = hdr_cnt_q + 4'd1;
					end
				end
				PH_REC_LEN, PH_REC_TYPE, PH_REC_VALUE: begin
					if (!stop_q) begin
						unique case (phase_q)
							PH_REC_LEN: begin
								// zero length or overrun ends the walk
								if (data_byte == 8'd0 || data_byte >= data_rem_q) begin
									stop_n = 1'b1;
								end else begin
									rec_rem_n = data_byte;
									phase_n   = PH_REC_TYPE;
								end
							end
							PH_REC_TYPE: begin
								rec_rem_n = rr;
								is_name_n = (data_byte == blearp_pkg::AD_SHORT_NAME ||
								             data_byte == blearp_pkg::AD_COMPLETE_NAME) &&
								            rr <= NB8;
								wr_idx_n  = '0;
								phase_n   = (rr != 8'd0) ? PH_REC_VALUE : PH_REC_LEN;
							end
							default: begin
								if (is_name_q && wr_idx_q < NBW) begin
									mem_wr_en = 1'b1;
									wr_idx_n  = wr_idx_q + IW1'(1);
								end
								rec_rem_n = rr;
								if (rr == 8'd0) begin
									phase_n = PH_REC_LEN;
								end
							end
						endcase
					end
					data_rem_n = data_rem_q - 8'd1;
					if (data_rem_n == 8'd0) begin
						phase_n = PH_RSSI;
					end
				end
				PH_RSSI: begin
					sum.valid  = 1'b1;
					sum.status = blearp_pkg::ST_OK;
					sum.addr   = addr_q;
					sum.rssi   = data_byte;
					sum.burst  = 1'b1;
					emitted_n  = 1'b1;
					phase_n    = PH_DRAIN;
				end
				default: ;
			endcase
			if (end_of_packet) begin
				if (!emitted_n) begin
					sum.valid  = 1'b1;
					sum.status = blearp_pkg::ST_TRUNC;
					sum.addr   = addr_n;
					sum.rssi   = '0;
					sum.last   = 1'b1;
				end
				phase_n    = PH_HEADER;
				hdr_cnt_n  = '0;
				data_rem_n = '0;
				rec_rem_n  = '0;
				is_name_n  = 1'b0;
				stop_n     = 1'b0;
				wr_idx_n   = '0;
				addr_n     = '0;
				emitted_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			data_rem_q <= '0;
			rec_rem_q  <= '0;
			is_name_q  <= 1'b0;
			stop_q     <= 1'b0;
			wr_idx_q   <= '0;
			addr_q     <= '0;
			emitted_q  <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			hdr_cnt_q  <= hdr_cnt_n;
			data_rem_q <= data_rem_n;
			rec_rem_q  <= rec_rem_n;
			is_name_q  <= is_name_n;
			stop_q     <= stop_n;
			wr_idx_q   <= wr_idx_n;
			addr_q     <= addr_n;
			emitted_q  <= emitted_n;
		end
	end

endmodule

### rtl/blearp_emit.sv
module blearp_emit #(
	parameter int NAME_BYTES = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  blearp_pkg::summary_t          sum,
	output logic                          in_ready,
	output logic                          rd_en,
	output logic [$clog2(NAME_BYTES)-1:0] rd_idx,
	input  logic [7:0]                    rd_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_kind,
	output blearp_pkg::status_t           out_status,
	output logic [blearp_pkg::ADDR_W-1:0] out_addr,
	output logic signed [7:0]             out_rssi,
	output logic [7:0]                    out_name_byte,
	output logic [blearp_pkg::POS_W-1:0]  out_name_pos,
	output logic                          out_last
);

	localparam int IW  = $clog2(NAME_BYTES);
	localparam int IW1 = $clog2(NAME_BYTES + 1);
	localparam logic [IW1-1:0] NBW     = IW1'(NAME_BYTES);
	localparam logic [IW-1:0]  LAST_IX = IW'(NAME_BYTES - 1);

	logic           busy_q;
	logic [IW1-1:0] rd_cnt_q;
	logic           pend_s1;
	logic [IW-1:0]  idx_s1;
	logic           out_free, load_name, burst_end;

	assign out_free  = !out_valid || out_ready;
	assign load_name = pend_s1 && out_free;
	assign burst_end = load_name && idx_s1 == LAST_IX;
	assign in_ready  = !busy_q && out_free;
	assign rd_en     = busy_q && rd_cnt_q < NBW && (!pend_s1 || load_name);
	assign rd_idx    = rd_cnt_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_cnt_q  <= '0;
			pend_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (sum.valid && sum.burst) begin
				busy_q   <= 1'b1;
				rd_cnt_q <= '0;
			end else begin
				if (burst_end) begin
					busy_q <= 1'b0;
				end
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + IW1'(1);
				end
			end
			if (rd_en) begin
				pend_s1 <= 1'b1;
			end else if (load_name) begin
				pend_s1 <= 1'b0;
			end
			if (sum.valid || load_name) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_idx;
		end
		if (sum.valid) begin
			out_kind      <= 1'b0;
			out_status    <= sum.status;
			out_addr      <= sum.addr;
			out_rssi      <= sum.rssi;
			out_name_byte <= 8'h00;
			out_name_pos  <= '0;
			out_last      <= sum.last;
		end else if (load_name) begin
			out_kind      <= 1'b1;
			out_status    <= blearp_pkg::ST_OK;
			out_addr      <= '0;
			out_rssi      <= '0;
			out_name_byte <= rd_data;
			out_name_pos  <= blearp_pkg::POS_W'(idx_s1);
			out_last      <= idx_s1 == LAST_IX;
		end
	end

`ifndef SYNTHESIS
	a_sum_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sum.valid |-> out_free)
		else $error("summary loaded over an untaken result");
	a_sum_not_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		sum.valid |-> !busy_q && !pend_s1)
		else $error("summary request during a name burst");
	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		burst_end |=> !busy_q && !pend_s1)
		else $error("name burst did not close after the last entry");
	a_pend_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> busy_q)
		else $error("name read outstanding outside a burst");
`endif

endmodule

### rtl/ble_adv_report_parser.sv
// Channel | Dir | Handshake         | Payload
// s_      | in  | s_tvalid/s_tready | tdata: data_byte; tlast: end_of_packet
// m_      | out | m_tvalid/m_tready | tdata: status, device_address, signal_strength,
//         |     |                   |   name_byte, name_position; tuser: kind; tlast: last
//
// Packet bytes are taken one per cycle while input is not stalled; every header and
// AD byte updates the parser registers and at most one name store entry in the cycle
// it is accepted. The RSSI byte queues the summary and starts a name burst: NAME_BYTES
// reads of the name store, one per cycle while m_tready holds, so input stalls for the
// whole burst, longer when m_tready drops.
// Input also stalls while any result sits in the output register untaken.
// Reset clears all control state and the name store valid bits at once; no clearing pass.
module ble_adv_report_parser #(
	parameter int NAME_BYTES = 31
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] status, [49:2] device_address, [57:50] signal_strength,
	// [65:58] name_byte, [70:66] name_position, [71] zero
	output logic [blearp_pkg::TDATA_W-1:0] m_tdata,
	output logic                           m_tuser,   // [0] kind
	output logic                           m_tlast
);

	localparam int IW = $clog2(NAME_BYTES);

	logic                          in_fire;
	logic                          mem_clear, mem_wr_en, rd_en;
	logic [IW-1:0]                 mem_wr_idx, rd_idx;
	logic [7:0]                    mem_wr_data, rd_data;
	blearp_pkg::summary_t          sum;
	blearp_pkg::status_t           out_status;
	logic [blearp_pkg::ADDR_W-1:0] out_addr;
	logic signed [7:0]             out_rssi;
	logic [7:0]                    out_name_byte;
	logic [blearp_pkg::POS_W-1:0]  out_name_pos;

	// a request is taken only when the output register is free and no burst runs
	assign in_fire = s_tvalid && s_tready;

	blearp_parse #(.NAME_BYTES(NAME_BYTES)) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.data_byte    (s_tdata),
		.end_of_packet(s_tlast),
		.mem_clear    (mem_clear),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_idx   (mem_wr_idx),
		.mem_wr_data  (mem_wr_data),
		.sum          (sum)
	);

	// writes happen only on accepted bytes and reads only during a burst, when input
	// is held, so the two never touch the store in the same cycle
	blearp_name_mem #(.NAME_BYTES(NAME_BYTES)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (mem_clear),
		.wr_en  (mem_wr_en),
		.wr_idx (mem_wr_idx),
		.wr_data(mem_wr_data),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_data(rd_data)
	);

	blearp_emit #(.NAME_BYTES(NAME_BYTES)) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum          (sum),
		.in_ready     (s_tready),
		.rd_en        (rd_en),
		.rd_idx       (rd_idx),
		.rd_data      (rd_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (m_tuser),
		.out_status   (out_status),
		.out_addr     (out_addr),
		.out_rssi     (out_rssi),
		.out_name_byte(out_name_byte),
		.out_name_pos (out_name_pos),
		.out_last     (m_tlast)
	);

	// pack the result fields, lowest field first, padded to whole bytes
	assign m_tdata = {1'b0, out_name_pos, out_name_byte, out_rssi, out_addr, out_status};

endmodule

### dv/ble_adv_report_parser_tb.sv
`timescale 1ns / 1ps

import blearp_pkg::*;

typedef logic [7:0] byte_q_t[$];

// One result as seen on the master side, unpacked into its fields.
typedef struct packed {
	logic              kind;
	status_t           status;
	logic [ADDR_W-1:0] addr;
	logic [7:0]        rssi;
	logic [7:0]        name_byte;
	logic [POS_W-1:0]  name_pos;
	logic              last;
} adv_result_t;

// Tracks the parser state per accepted request and holds the results it owes.
class adv_report_tracker #(int NAME_LEN = 31);

	typedef enum int {
		STG_HEADER,
		STG_REC_LEN,
		STG_REC_TYPE,
		STG_REC_VALUE,
		STG_RSSI,
		STG_DRAIN
	} stage_t;

	stage_t            stage;
	int                hdr_idx;
	logic [7:0]        data_left;
	logic [7:0]        rec_left;
	bit                rec_carries_name;
	bit                walk_done;
	logic [7:0]        names[NAME_LEN];
	int                name_wr;
	logic [ADDR_W-1:0] addr_acc;
	bit                reported;

	adv_result_t pending[$];
	int          mismatches;

	function new();
		foreach (names[i]) names[i] = 8'h00;
		start_packet();
		mismatches = 0;
	endfunction

	function void start_packet();
		stage            = STG_HEADER;
		hdr_idx          = 0;
		data_left        = 8'd0;
		rec_left         = 8'd0;
		rec_carries_name = 1'b0;
		walk_done        = 1'b0;
		name_wr          = 0;
		addr_acc         = '0;
		reported         = 1'b0;
	endfunction

	function void owe(logic kind, status_t st, logic [ADDR_W-1:0] addr, logic [7:0] rssi,
			logic [7:0] nb, logic [POS_W-1:0] pos, logic last);
		adv_result_t r;
		r.kind      = kind;
		r.status    = st;
		r.addr      = addr;
		r.rssi      = rssi;
		r.name_byte = nb;
		r.name_pos  = pos;
		r.last      = last;
		pending.push_back(r);
	endfunction

	// Advance the length-type-value walk over one AD byte.
	function void walk_ad(logic [7:0] b);
		if (walk_done)
			return;
		case (stage)
			STG_REC_LEN: begin
				// stop on a zero length or one that runs past the data
				if (b == 8'd0 || int'(b) > int'(data_left) - 1) begin
					walk_done = 1'b1;
				end else begin
					rec_left = b;
					stage    = STG_REC_TYPE;
				end
			end
			STG_REC_TYPE: begin
				rec_left--;
				rec_carries_name = (b == AD_SHORT_NAME || b == AD_COMPLETE_NAME) &&
						int'(rec_left) <= NAME_LEN;
				name_wr = 0;
				stage   = (rec_left != 8'd0) ? STG_REC_VALUE : STG_REC_LEN;
			end
			default: begin
				if (rec_carries_name && name_wr < NAME_LEN) begin
					names[name_wr] = b;
					name_wr++;
				end
				rec_left--;
				if (rec_left == 8'd0)
					stage = STG_REC_LEN;
			end
		endcase
	endfunction

	// Note one accepted request and queue the results it causes.
	function void note_request(logic [7:0] b, logic eop);
		case (stage)
			STG_HEADER: begin
				if (hdr_idx == int'(HDR_FIRST))
					foreach (names[i]) names[i] = 8'h00;
				if (hdr_idx == int'(HDR_SUBEVENT) && b != SUBEV_ADV_REPORT) begin
					owe(1'b0, (b == SUBEV_CONN_DONE) ? ST_DONE : ST_WRONG, addr_acc,
							8'd0, 8'd0, '0, 1'b1);
					reported = 1'b1;
					stage    = STG_DRAIN;
				end else if (hdr_idx == int'(HDR_DATA_LEN)) begin
					data_left = b;
					stage     = (b != 8'd0) ? STG_REC_LEN : STG_RSSI;
				end else begin
					if (hdr_idx >= int'(HDR_ADDR_FIRST) &&
							hdr_idx < int'(HDR_ADDR_FIRST) + ADDR_BYTES)
						addr_acc[8*(hdr_idx-int'(HDR_ADDR_FIRST)) +: 8] = b;
					hdr_idx++;
				end
			end
			STG_REC_LEN, STG_REC_TYPE, STG_REC_VALUE: begin
				walk_ad(b);
				data_left--;
				if (data_left == 8'd0)
					stage = STG_RSSI;
			end
			STG_RSSI: begin
				owe(1'b0, ST_OK, addr_acc, b, 8'd0, '0, 1'b0);
				for (int i = 0; i < NAME_LEN; i++)
					owe(1'b1, ST_OK, '0, 8'd0, names[i], POS_W'(i), i == NAME_LEN - 1);
				reported = 1'b1;
				stage    = STG_DRAIN;
			end
			default: ;
		endcase

		if (eop) begin
			if (!reported)
				owe(1'b0, ST_TRUNC, addr_acc, 8'd0, 8'd0, '0, 1'b1);
			start_packet();
		end
	endfunction

	function string fmt_result(adv_result_t r);
		return $sformatf("kind=%0d status=%0d addr=%h rssi=%h name=%h pos=%0d last=%0d",
				r.kind, r.status, r.addr, r.rssi, r.name_byte, r.name_pos, r.last);
	endfunction

	// Compare one taken result with the oldest one owed.
	function void check_result(logic [TDATA_W-1:0] tdata, logic tuser, logic tlast);
		adv_result_t got;
		adv_result_t want;
		got.kind      = tuser;
		got.status    = status_t'(tdata[1:0]);
		got.addr      = tdata[49:2];
		got.rssi      = tdata[57:50];
		got.name_byte = tdata[65:58];
		got.name_pos  = tdata[70:66];
		got.last      = tlast;

		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: %s", fmt_result(got));
			return;
		end

		want = pending.pop_front();
		if (got !== want || tdata[TDATA_W-1] !== 1'b0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result mismatch at %0t", $realtime);
				$display("  expected %s", fmt_result(want));
				$display("  actual   %s pad=%b", fmt_result(got), tdata[TDATA_W-1]);
			end
		end
	endfunction

endclass

module ble_adv_report_parser_tb;

	localparam int NAME_LEN       = 31;
	localparam int RANDOM_BYTES   = 340;
	localparam int CALM_AFTER     = 280;
	localparam int WATCHDOG_LIMIT = 1000;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	adv_report_tracker #(NAME_LEN) tracker;

	int bytes_sent;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	ble_adv_report_parser #(
		.NAME_BYTES(NAME_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one packet byte, with an optional idle burst ahead of it, and hold
	// it until the parser takes the request.
	task automatic send_byte(input logic [7:0] b, input logic eop);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eop;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_request(b, eop);
		bytes_sent++;
	endtask

	task automatic send_packet(input byte_q_t pkt);
		foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// Hold the sender until every owed result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	// Header bytes 0 through 12; unchecked bytes are random.
	function automatic byte_q_t head_bytes(logic [7:0] subev, logic [ADDR_W-1:0] addr);
		byte_q_t h;
		h = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), subev};
		repeat (3) h.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < ADDR_BYTES; i++) h.push_back(addr[8*i +: 8]);
		return h;
	endfunction

	// AD data of the given length: mostly proper records, name records often,
	// now and then a zero length or a length that overruns the data.
	function automatic byte_q_t make_ad_data(int len);
		byte_q_t d;
		int      left;
		int      pick;
		int      vlen;
		left = len;
		while (left > 0) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				d.push_back(8'h00);
				left--;
			end else if (pick == 1 || left == 1) begin
				d.push_back(8'($urandom_range(left, 255)));
				left--;
			end else begin
				vlen = (pick < 5) ? $urandom_range(0, 33) : $urandom_range(0, 10);
				if (vlen > left - 2)
					vlen = left - 2;
				d.push_back(8'(vlen + 1));
				if (pick < 14)
					d.push_back(pick[0] ? AD_SHORT_NAME : AD_COMPLETE_NAME);
				else
					d.push_back(8'($urandom_range(0, 255)));
				repeat (vlen) d.push_back(8'($urandom_range(0, 255)));
				left -= vlen + 2;
			end
		end
		return d;
	endfunction

	function automatic byte_q_t make_packet();
		byte_q_t     p;
		logic [7:0]  subev;
		int          r;
		int          dlen;
		int          rssi_idx;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// connection complete, rest ignored
			p = head_bytes(SUBEV_CONN_DONE, {16'($urandom), 32'($urandom)});
			p = p[0:$urandom_range(int'(HDR_SUBEVENT), p.size() - 1)];
		end else if (r < 15) begin
			do subev = 8'($urandom_range(0, 255));
			while (subev == SUBEV_CONN_DONE || subev == SUBEV_ADV_REPORT);
			p = head_bytes(subev, {16'($urandom), 32'($urandom)});
			p = p[0:$urandom_range(int'(HDR_SUBEVENT), p.size() - 1)];
		end else if (r < 92) begin
			dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
			p = head_bytes(SUBEV_ADV_REPORT, {16'($urandom), 32'($urandom)});
			p.push_back(8'(dlen));
			p = {p, make_ad_data(dlen)};
			rssi_idx = p.size();
			p.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 3)) p.push_back(8'($urandom_range(0, 255)));
			// cut some reports short before the RSSI byte
			if (r >= 77)
				p = p[0:$urandom_range(0, rssi_idx - 1)];
		end else begin
			repeat ($urandom_range(1, 24)) p.push_back(8'($urandom_range(0, 255)));
		end
		return p;
	endfunction

	// Check every taken result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata, m_tuser, m_tlast);
	end

	// End the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: stall in short random bursts while stall_pct is nonzero.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		byte_q_t p;

		tracker      = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		bytes_sent   = 0;
		idle_pct     = 0;
		stall_pct    = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 30;
		stall_pct = 30;

		// lone byte with end of packet: truncated, nothing gathered
		p = {8'h04};
		send_packet(p);

		// connection complete, packet ends on the subevent byte
		p = {8'h04, 8'h3E, 8'h13, SUBEV_CONN_DONE};
		send_packet(p);

		// wrong event, one byte left to drain
		p = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAA};
		send_packet(p);

		// report with all-ones address, no AD data, largest RSSI
		p = head_bytes(SUBEV_ADV_REPORT, {ADDR_W{1'b1}});
		p = {p, 8'h00, 8'h7F};
		send_packet(p);

		// two names (second overwrites the front), then a zero length stops the walk
		p = head_bytes(SUBEV_ADV_REPORT, '0);
		p = {p, 8'd12, 8'h05, AD_SHORT_NAME, 8'h61, 8'h62, 8'h63, 8'h64,
				8'h03, AD_COMPLETE_NAME, 8'h65, 8'h66, 8'h00, 8'h77, 8'h80, 8'h55};
		send_packet(p);

		// name of full store size, a name one byte too long, then an overrun
		p = head_bytes(SUBEV_ADV_REPORT, 48'h5A5A_A5A5_0F0F);
		p.push_back(8'd68);
		p.push_back(8'(NAME_LEN + 1));
		p.push_back(AD_COMPLETE_NAME);
		repeat (NAME_LEN) p.push_back(8'($urandom_range(0, 255)));
		p.push_back(8'(NAME_LEN + 2));
		p.push_back(AD_SHORT_NAME);
		repeat (NAME_LEN + 1) p.push_back(8'($urandom_range(0, 255)));
		p = {p, 8'hFF, 8'h12, 8'h01};
		send_packet(p);

		// next report must see a cleared store
		p = head_bytes(SUBEV_ADV_REPORT, {16'($urandom), 32'($urandom)});
		p = {p, 8'h00, 8'hC3};
		send_packet(p);

		// truncated in the middle of the address
		p = {8'h04, 8'h3E, 8'h13, SUBEV_ADV_REPORT, 8'h00, 8'h00, 8'h00,
				8'h11, 8'h22, 8'h33};
		send_packet(p);

		drain_results();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= CALM_AFTER) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = 25 * $urandom_range(0, 2);
				stall_pct = 25 * $urandom_range(0, 2);
			end
			send_packet(make_packet());
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end

		drain_results();
		repeat (40) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
